/* design/rmhf_pkg.sv */
// ----------------------------------------------------------------------------
// rmhf_pkg: shared definitions for the running median histogram filter
// Default sizes, field widths, configuration register indexes and the
// reset values of the clamp levels.
// ----------------------------------------------------------------------------
package rmhf_pkg;

  // default sizes, handed to the top level as parameter defaults
  localparam int WINDOW_DEF   = 64;
  localparam int BINS_DEF     = 128;
  localparam int CHANNELS_DEF = 3;

  // fixed field widths
  localparam int SUM_W     = 13;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL = 1'b1;

  // reset values of the clamp registers
  localparam logic [CFG_W-1:0] MIN_LEVEL_RESET = 11'd50;
  localparam logic [CFG_W-1:0] MAX_LEVEL_RESET = 11'd1074;

endpackage

/* design/rmhf_if.sv */
// ----------------------------------------------------------------------------
// rmhf_in_if / rmhf_out_if: valid/ready channels of the median filter
// The input channel carries a channel number and a sum of eight
// conversions; the result channel carries channel, level and median.
// ----------------------------------------------------------------------------
interface rmhf_in_if #(
  parameter int CH_W = 2
);
  import rmhf_pkg::*;

  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  channel;
  logic [SUM_W-1:0] sample_sum;

  modport source (output valid, output channel, output sample_sum, input ready);
  modport sink   (input valid, input channel, input sample_sum, output ready);
endinterface

interface rmhf_out_if #(
  parameter int CH_W = 2,
  parameter int LV_W = 7
);
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_channel;
  logic [LV_W-1:0] level;
  logic [LV_W-1:0] median;

  modport source (output valid, output out_channel, output level, output median,
                  input ready);
  modport sink   (input valid, input out_channel, input level, input median,
                  output ready);
endinterface

/* design/running_median_histogram_filter.sv */
// ----------------------------------------------------------------------------
// running_median_histogram_filter: per-channel running median of levels
// Normalises each averaged sample to a level, keeps a ring of the last
// WINDOW levels per channel and a count tree over the level bins, and
// reports the (WINDOW/2)-th smallest level once the window is full.
// ----------------------------------------------------------------------------
// Each input word carries a channel number and the sum of eight conversions.
// The block averages it (sum >> 3), clamps it to [min_level, max_level],
// subtracts min_level, shifts right by 3 and saturates at BINS-1 to form a
// level. After reset the count tree is swept to zero, one entry a cycle, over
// its CHANNELS * 2^(clog2(BINS)+1) used entries (768 with the defaults);
// configuration writes are taken meanwhile but no input word is accepted.
// An item then runs these steps up to its result being loaded into the
// output register: form the level and read the ring, rewrite the ring,
// one tree pass to remove the oldest level, one to insert the new level,
// one for the rank descent, and load the output. All three passes run
// through the same count tree memory, one read and one write a cycle.
// The first WINDOW words of a channel only fill its window and give no
// result. A word whose channel is CHANNELS or above is accepted and
// dropped. The next word is accepted as soon as the sequencer is back at
// idle, even while a result still waits in the output register; a result
// waits for the register to be free. Write configuration only while the
// block is idle.
// ----------------------------------------------------------------------------
module running_median_histogram_filter #(
  parameter int WINDOW   = rmhf_pkg::WINDOW_DEF,
  parameter int BINS     = rmhf_pkg::BINS_DEF,
  parameter int CHANNELS = rmhf_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rmhf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rmhf_pkg::CFG_W-1:0]     cfg_wdata,
  rmhf_in_if.sink                       in_ch,
  rmhf_out_if.source                    out_ch
);
  import rmhf_pkg::*;

  // derived sizes
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LV_W     = $clog2(BINS);       // tree depth equals level width
  localparam int NODE_W   = LV_W + 1;           // heap node number, root is 1
  localparam int WP_W     = $clog2(WINDOW);
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int K_W      = $clog2(LV_W + 1);
  localparam int TM_AW    = CH_W + NODE_W;
  localparam int TM_DEPTH = 1 << TM_AW;
  localparam int TM_USED  = CHANNELS << NODE_W;
  localparam int RG_AW    = CH_W + WP_W;
  localparam int RG_DEPTH = 1 << RG_AW;
  localparam int RANK     = WINDOW / 2;

  // sequencer states
  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_LEVEL = 8'b0000_0100,
    S_RING  = 8'b0000_1000,
    S_REM   = 8'b0001_0000,
    S_INS   = 8'b0010_0000,
    S_DESC  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [TM_AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic [K_W-1:0]      k_r, k_nxt;
  logic [NODE_W-1:0]   node_r, node_nxt;
  logic [NODE_W-1:0]   prev_r, prev_nxt;
  logic [NODE_W-1:0]   dnode_r, dnode_nxt;
  logic [CNT_W-1:0]    rank_r, rank_nxt;
  logic [CH_W-1:0]     ch_r, ch_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [LV_W-1:0]     lv_r, lv_nxt;
  logic                primed_r, primed_nxt;
  logic [CFG_W-1:0]    min_r, min_nxt;
  logic [CFG_W-1:0]    max_r, max_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CH_W-1:0]     out_ch_r, out_ch_nxt;
  logic [LV_W-1:0]     out_lv_r, out_lv_nxt;
  logic [LV_W-1:0]     out_med_r, out_med_nxt;
  logic [WP_W-1:0]     wp_r [CHANNELS];
  logic [WP_W-1:0]     wp_nxt [CHANNELS];
  logic [CNT_W-1:0]    fill_r [CHANNELS];
  logic [CNT_W-1:0]    fill_nxt [CHANNELS];

  // memories
  logic [CNT_W-1:0]    tm_mem [TM_DEPTH];
  logic [CNT_W-1:0]    tm_rdata_r;
  logic                tm_we;
  logic [TM_AW-1:0]    tm_waddr;
  logic [TM_AW-1:0]    tm_raddr;
  logic [CNT_W-1:0]    tm_wdata;
  logic [LV_W-1:0]     ring_mem [RG_DEPTH];
  logic [LV_W-1:0]     ring_rdata_r;
  logic                rg_we;
  logic [RG_AW-1:0]    rg_waddr;
  logic [RG_AW-1:0]    rg_raddr;

  // datapath helpers
  logic                in_fire;
  logic                ch_ok;
  logic                pass_end;
  logic                out_free;
  logic [WP_W-1:0]     wp_sel;
  logic [WP_W-1:0]     wp_step;
  logic [CFG_W-1:0]    avg;
  logic [CFG_W-1:0]    clamped;
  logic [CFG_W-1:0]    diff;
  logic [LV_W-1:0]     lv_calc;
  logic                go_right;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign in_fire            = in_ch.valid && in_ch.ready;
  assign ch_ok              = (32'(in_ch.channel) < 32'(CHANNELS));
  assign pass_end           = (k_r == K_W'(LV_W));
  assign out_free           = !out_valid_r || out_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_channel = out_ch_r;
  assign out_ch.level       = out_lv_r;
  assign out_ch.median      = out_med_r;

  // ring pointer of the current channel, wrapping at WINDOW
  assign wp_sel  = wp_r[ch_r];
  assign wp_step = (wp_sel == WP_W'(WINDOW - 1)) ? '0 : wp_sel + 1'b1;

  // level: average, clamp, offset, scale and saturate
  always_comb begin
    avg = CFG_W'(sum_r >> 3);
    if (avg < min_r) begin
      clamped = min_r;
    end else if (avg > max_r) begin
      clamped = max_r;
    end else begin
      clamped = avg;
    end
    diff = clamped - min_r;
    if (clamped <= min_r) begin
      lv_calc = '0;
    end else if (32'(diff >> 3) > 32'(BINS - 1)) begin
      lv_calc = LV_W'(BINS - 1);
    end else begin
      lv_calc = LV_W'(diff >> 3);
    end
  end

  // descent step: go right when the rank lies beyond the left subtree
  assign go_right = (rank_r > tm_rdata_r);

  // ring port
  assign rg_we    = (state_r == S_RING);
  assign rg_waddr = {ch_r, wp_sel};
  assign rg_raddr = {ch_r, wp_step};

  // count tree port: clearing sweep, update passes, descent
  always_comb begin
    tm_we    = 1'b0;
    tm_waddr = {ch_r, prev_r};
    tm_wdata = tm_rdata_r + 1'b1;
    tm_raddr = {ch_r, node_r};
    case (state_r)
      S_CLEAR: begin
        tm_we    = 1'b1;
        tm_waddr = clr_addr_r;
        tm_wdata = '0;
      end
      S_REM: begin
        tm_we    = (k_r != '0);
        tm_wdata = tm_rdata_r - 1'b1;
      end
      S_INS: begin
        tm_we    = (k_r != '0);
      end
      S_DESC: begin
        tm_raddr = {ch_r, dnode_nxt[LV_W-1:0], 1'b0};
      end
      default: begin
        tm_we    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tm_we) begin
      tm_mem[tm_waddr] <= tm_wdata;
    end
    tm_rdata_r <= tm_mem[tm_raddr];
  end

  always_ff @(posedge clk) begin
    if (rg_we) begin
      ring_mem[rg_waddr] <= lv_r;
    end
    ring_rdata_r <= ring_mem[rg_raddr];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    k_nxt         = k_r;
    node_nxt      = node_r;
    prev_nxt      = prev_r;
    dnode_nxt     = dnode_r;
    rank_nxt      = rank_r;
    ch_nxt        = ch_r;
    sum_nxt       = sum_r;
    lv_nxt        = lv_r;
    primed_nxt    = primed_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_ch_nxt    = out_ch_r;
    out_lv_nxt    = out_lv_r;
    out_med_nxt   = out_med_r;
    for (int c = 0; c < CHANNELS; c++) begin
      wp_nxt[c]   = wp_r[c];
      fill_nxt[c] = fill_r[c];
    end

    // configuration words land at any time
    if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_LEVEL: min_nxt = cfg_wdata;
        CFG_MAX_LEVEL: max_nxt = cfg_wdata;
        default:       min_nxt = min_r;
      endcase
    end

    case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == TM_AW'(TM_USED - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        // capture the word; drop it when the channel is out of range
        if (in_fire) begin
          ch_nxt  = in_ch.channel;
          sum_nxt = in_ch.sample_sum;
          if (ch_ok) begin
            state_nxt = S_LEVEL;
          end
        end
      end
      S_LEVEL: begin
        // form the level, advance the ring pointer, read the oldest level
        lv_nxt           = lv_calc;
        wp_nxt[ch_r]     = wp_step;
        primed_nxt       = (fill_r[ch_r] == CNT_W'(WINDOW));
        if (fill_r[ch_r] != CNT_W'(WINDOW)) begin
          fill_nxt[ch_r] = fill_r[ch_r] + 1'b1;
        end
        state_nxt        = S_RING;
      end
      S_RING: begin
        // overwrite the ring slot; remove the old level once primed
        k_nxt = '0;
        if (primed_r) begin
          node_nxt  = {1'b1, ring_rdata_r};
          state_nxt = S_REM;
        end else begin
          node_nxt  = {1'b1, lv_r};
          state_nxt = S_INS;
        end
      end
      S_REM: begin
        prev_nxt = node_r;
        node_nxt = node_r >> 1;
        k_nxt    = k_r + 1'b1;
        if (pass_end) begin
          k_nxt     = '0;
          node_nxt  = {1'b1, lv_r};
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        prev_nxt = node_r;
        node_nxt = node_r >> 1;
        k_nxt    = k_r + 1'b1;
        if (pass_end) begin
          k_nxt     = '0;
          dnode_nxt = NODE_W'(1);
          rank_nxt  = CNT_W'(RANK);
          state_nxt = primed_r ? S_DESC : S_IDLE;
        end
      end
      S_DESC: begin
        // one tree level a cycle, left child count in tm_rdata_r
        k_nxt = k_r + 1'b1;
        if (k_r != '0) begin
          dnode_nxt = {dnode_r[LV_W-1:0], go_right};
          if (go_right) begin
            rank_nxt = rank_r - tm_rdata_r;
          end
        end
        if (pass_end) begin
          k_nxt     = '0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ch_nxt    = ch_r;
          out_lv_nxt    = lv_r;
          out_med_nxt   = dnode_r[LV_W-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      k_r         <= '0;
      primed_r    <= 1'b0;
      min_r       <= MIN_LEVEL_RESET;
      max_r       <= MAX_LEVEL_RESET;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        wp_r[c]   <= WP_W'(WINDOW - 1);
        fill_r[c] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      k_r         <= k_nxt;
      primed_r    <= primed_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      out_valid_r <= out_valid_nxt;
      for (int c = 0; c < CHANNELS; c++) begin
        wp_r[c]   <= wp_nxt[c];
        fill_r[c] <= fill_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    node_r    <= node_nxt;
    prev_r    <= prev_nxt;
    dnode_r   <= dnode_nxt;
    rank_r    <= rank_nxt;
    ch_r      <= ch_nxt;
    sum_r     <= sum_nxt;
    lv_r      <= lv_nxt;
    out_ch_r  <= out_ch_nxt;
    out_lv_r  <= out_lv_nxt;
    out_med_r <= out_med_nxt;
  end

  // assertions
  a_drop_bad_channel: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !ch_ok |=> state_r == S_IDLE)
    else $error("out-of-range channel word was not dropped");

  a_start_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && ch_ok |=> state_r == S_LEVEL)
    else $error("accepted word did not start the sequencer");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RING |-> fill_r[ch_r] <= CNT_W'(WINDOW))
    else $error("fill count ran past the window");

  a_desc_primed: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DESC |-> primed_r && rank_r != '0)
    else $error("rank descent without a full window or with a zero rank");

  a_result_only_primed: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !$past(out_ch.valid) |-> $past(state_r == S_OUT) && primed_r)
    else $error("result raised outside the output step");

endmodule
